[hw/rtl/sbpg_pkg.sv]
// Shared widths, configuration types and reset values for the soft band pixel generator.
package sbpg_pkg;

    localparam int COORD_WIDTH_DEF = 12;

    localparam int NRM_W      = 16;
    localparam int EDGE_W     = 18;
    localparam int HW_W       = 14;
    localparam int LVL_W      = 8;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    // Edges and half width are Q.4; the projection is Q.14.
    localparam int EDGE_SHIFT = 10;
    localparam int UV_W       = HW_W + EDGE_SHIFT + 2;
    localparam int MUL_W      = LVL_W + UV_W;
    localparam int NUM_SHIFT  = EDGE_SHIFT + 1;
    localparam int NUM_W      = LVL_W + HW_W;

    localparam int PROJ_STAGES = 3;
    localparam int CLS_STAGES  = 3;
    localparam int DIV_STAGES  = LVL_W;
    localparam int NUM_STAGES  = PROJ_STAGES + CLS_STAGES + DIV_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X,
        CFG_NORMAL_Y,
        CFG_FIRST_EDGE,
        CFG_SECOND_EDGE,
        CFG_RAMP_HALF_WIDTH,
        CFG_LEVEL_LOW,
        CFG_LEVEL_MID,
        CFG_LEVEL_HIGH
    } t_cfg_idx;

    typedef struct packed {
        logic signed [NRM_W-1:0]  normal_x;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [EDGE_W-1:0] first_edge;
        logic signed [EDGE_W-1:0] second_edge;
        logic        [HW_W-1:0]   ramp_half_width;
        logic        [LVL_W-1:0]  level_low;
        logic        [LVL_W-1:0]  level_mid;
        logic        [LVL_W-1:0]  level_high;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        normal_x:        16'sd16384,
        normal_y:        16'sd0,
        first_edge:      18'sd0,
        second_edge:     18'sd0,
        ramp_half_width: 14'd0,
        level_low:       8'd0,
        level_mid:       8'd128,
        level_high:      8'd255
    };

    // Width of the projection sum for a given coordinate width.
    function automatic int proj_w(int cw);
        return cw + NRM_W + 1;
    endfunction

    // Width of the projection minus an edge distance.
    function automatic int diff_w(int cw);
        int ew;
        ew = EDGE_W + EDGE_SHIFT;
        return ((proj_w(cw) > ew) ? proj_w(cw) : ew) + 1;
    endfunction

endpackage

[hw/rtl/sbpg_regs.sv]
// Configuration register file of the soft band pixel generator.
module sbpg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sbpg_pkg::t_cfg                   o_cfg
);
    import sbpg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NORMAL_X:        n_cfg.normal_x        = i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y:        n_cfg.normal_y        = i_cfg_data[NRM_W-1:0];
                CFG_FIRST_EDGE:      n_cfg.first_edge      = i_cfg_data[EDGE_W-1:0];
                CFG_SECOND_EDGE:     n_cfg.second_edge     = i_cfg_data[EDGE_W-1:0];
                CFG_RAMP_HALF_WIDTH: n_cfg.ramp_half_width = i_cfg_data[HW_W-1:0];
                CFG_LEVEL_LOW:       n_cfg.level_low       = i_cfg_data[LVL_W-1:0];
                CFG_LEVEL_MID:       n_cfg.level_mid       = i_cfg_data[LVL_W-1:0];
                CFG_LEVEL_HIGH:      n_cfg.level_high      = i_cfg_data[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/sbpg_proj.sv]
// Projection of the pixel coordinate onto the normal and distances to both edges.
module sbpg_proj #(
    parameter int COORD_WIDTH = sbpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic [sbpg_pkg::PROJ_STAGES-1:0]                i_en,
    input  logic [COORD_WIDTH-1:0]                          i_row,
    input  logic [COORD_WIDTH-1:0]                          i_col,
    input  sbpg_pkg::t_cfg                                  i_cfg,
    output logic signed [sbpg_pkg::diff_w(COORD_WIDTH)-1:0] o_d0,
    output logic signed [sbpg_pkg::diff_w(COORD_WIDTH)-1:0] o_d1
);
    import sbpg_pkg::*;

    localparam int PW = proj_w(COORD_WIDTH);
    localparam int DW = diff_w(COORD_WIDTH);

    logic signed [PW-1:0] nx_ext;
    logic signed [PW-1:0] ny_ext;
    logic signed [PW-1:0] row_ext;
    logic signed [PW-1:0] col_ext;
    logic signed [DW-1:0] e0;
    logic signed [DW-1:0] e1;

    logic signed [PW-1:0] r_prod_x;
    logic signed [PW-1:0] r_prod_y;
    logic signed [PW-1:0] r_proj;
    logic signed [DW-1:0] r_d0;
    logic signed [DW-1:0] r_d1;

    assign nx_ext  = PW'(i_cfg.normal_x);
    assign ny_ext  = PW'(i_cfg.normal_y);
    assign row_ext = PW'({1'b0, i_row});
    assign col_ext = PW'({1'b0, i_col});

    // Edges move from Q.4 to the Q.14 of the projection.
    assign e0 = DW'(i_cfg.first_edge) <<< EDGE_SHIFT;
    assign e1 = DW'(i_cfg.second_edge) <<< EDGE_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod_x <= nx_ext * row_ext;
            r_prod_y <= ny_ext * col_ext;
        end
        if (i_en[1]) begin
            r_proj <= r_prod_x + r_prod_y;
        end
        if (i_en[2]) begin
            r_d0 <= DW'(r_proj) - e0;
            r_d1 <= DW'(r_proj) - e1;
        end
    end

    assign o_d0 = r_d0;
    assign o_d1 = r_d1;

endmodule

[hw/rtl/sbpg_cls.sv]
// Band classification and ramp numerator for the soft band pixel generator.
module sbpg_cls #(
    parameter int COORD_WIDTH = sbpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic [sbpg_pkg::CLS_STAGES-1:0]                 i_en,
    input  logic signed [sbpg_pkg::diff_w(COORD_WIDTH)-1:0] i_d0,
    input  logic signed [sbpg_pkg::diff_w(COORD_WIDTH)-1:0] i_d1,
    input  sbpg_pkg::t_cfg                                  i_cfg,
    output logic                                            o_ramp,
    output logic [sbpg_pkg::LVL_W-1:0]                      o_lvl,
    output logic [sbpg_pkg::NUM_W-1:0]                      o_num
);
    import sbpg_pkg::*;

    localparam int AW = diff_w(COORD_WIDTH) + 1;

    logic signed [AW-1:0] h_ext;
    logic signed [AW-1:0] a0;
    logic signed [AW-1:0] b0;
    logic signed [AW-1:0] v0;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] b1;
    logic signed [AW-1:0] v1;

    logic             n_ramp;
    logic [LVL_W-1:0] n_lvl;
    logic [LVL_W-1:0] n_lo;
    logic [LVL_W-1:0] n_hi;
    logic [UV_W-1:0]  n_u;
    logic [UV_W-1:0]  n_v;
    logic [MUL_W:0]   num_sum;

    logic             r_ramp3;
    logic [LVL_W-1:0] r_lvl3;
    logic [LVL_W-1:0] r_lo;
    logic [LVL_W-1:0] r_hi;
    logic [UV_W-1:0]  r_u;
    logic [UV_W-1:0]  r_v;
    logic             r_ramp4;
    logic [LVL_W-1:0] r_lvl4;
    logic [MUL_W-1:0] r_mlo;
    logic [MUL_W-1:0] r_mhi;
    logic             r_ramp5;
    logic [LVL_W-1:0] r_lvl5;
    logic [NUM_W-1:0] r_num;

    assign h_ext = AW'({1'b0, i_cfg.ramp_half_width, EDGE_SHIFT'(0)});

    // a = t + h and b = t - h for each edge; v = h - t.
    assign a0 = AW'(i_d0) + h_ext;
    assign b0 = AW'(i_d0) - h_ext;
    assign v0 = h_ext - AW'(i_d0);
    assign a1 = AW'(i_d1) + h_ext;
    assign b1 = AW'(i_d1) - h_ext;
    assign v1 = h_ext - AW'(i_d1);

    // The tests run in band order, so edges given out of order fall to the high level.
    always_comb begin
        n_ramp = 1'b0;
        n_lvl  = i_cfg.level_high;
        n_lo   = i_cfg.level_mid;
        n_hi   = i_cfg.level_high;
        n_u    = UV_W'(a1);
        n_v    = UV_W'(v1);
        if (a0[AW-1]) begin
            n_lvl = i_cfg.level_low;
        end else if (b0[AW-1]) begin
            n_ramp = 1'b1;
            n_lo   = i_cfg.level_low;
            n_hi   = i_cfg.level_mid;
            n_u    = UV_W'(a0);
            n_v    = UV_W'(v0);
        end else if (a1[AW-1]) begin
            n_lvl = i_cfg.level_mid;
        end else if (b1[AW-1]) begin
            n_ramp = 1'b1;
        end
    end

    assign num_sum = {1'b0, r_mlo} + {1'b0, r_mhi};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ramp3 <= n_ramp;
            r_lvl3  <= n_lvl;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_u     <= n_u;
            r_v     <= n_v;
        end
        if (i_en[1]) begin
            r_ramp4 <= r_ramp3;
            r_lvl4  <= r_lvl3;
            r_mlo   <= MUL_W'(r_lo) * MUL_W'(r_v);
            r_mhi   <= MUL_W'(r_hi) * MUL_W'(r_u);
        end
        if (i_en[2]) begin
            r_ramp5 <= r_ramp4;
            r_lvl5  <= r_lvl4;
            // The divisor 2h carries a factor of 2048, taken out here.
            r_num   <= num_sum[NUM_SHIFT +: NUM_W];
        end
    end

    assign o_ramp = r_ramp5;
    assign o_lvl  = r_lvl5;
    assign o_num  = r_num;

endmodule

[hw/rtl/sbpg_div.sv]
// Pipelined restoring divider giving one quotient bit per stage, with the final level select.
module sbpg_div (
    input  logic                             i_clk,
    input  logic [sbpg_pkg::DIV_STAGES-1:0]  i_en,
    input  logic                             i_ramp,
    input  logic [sbpg_pkg::LVL_W-1:0]       i_lvl,
    input  logic [sbpg_pkg::NUM_W-1:0]       i_num,
    input  logic [sbpg_pkg::HW_W-1:0]        i_hw,
    output logic [sbpg_pkg::LVL_W-1:0]       o_pixel
);
    import sbpg_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [NUM_W-1:0] s_rem  [DIV_STAGES];
    logic [LVL_W-1:0] s_quo  [DIV_STAGES];
    logic             s_ramp [DIV_STAGES];
    logic [LVL_W-1:0] s_lvl  [DIV_STAGES];

    logic [NUM_W-1:0] r_rem  [LAST];
    logic [LVL_W-1:0] r_quo  [LAST];
    logic             r_ramp [LAST];
    logic [LVL_W-1:0] r_lvl  [LAST];
    logic [LVL_W-1:0] r_pix;

    assign s_rem[0]  = i_num;
    assign s_quo[0]  = '0;
    assign s_ramp[0] = i_ramp;
    assign s_lvl[0]  = i_lvl;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        localparam int B = LAST - j;

        logic [NUM_W:0]   dvs;
        logic [NUM_W:0]   diff;
        logic             take;
        logic [LVL_W-1:0] quo_next;

        assign dvs      = {{(NUM_W + 1 - HW_W){1'b0}}, i_hw} << B;
        assign diff     = {1'b0, s_rem[j]} - dvs;
        assign take     = !diff[NUM_W];
        assign quo_next = take ? (s_quo[j] | (LVL_W'(1) << B)) : s_quo[j];

        if (j < LAST) begin : g_mid
            logic [NUM_W-1:0] rem_next;

            assign rem_next = take ? diff[NUM_W-1:0] : s_rem[j];

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= rem_next;
                    r_quo[j]  <= quo_next;
                    r_ramp[j] <= s_ramp[j];
                    r_lvl[j]  <= s_lvl[j];
                end
            end
            assign s_rem[j+1]  = r_rem[j];
            assign s_quo[j+1]  = r_quo[j];
            assign s_ramp[j+1] = r_ramp[j];
            assign s_lvl[j+1]  = r_lvl[j];
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_pix <= s_ramp[j] ? quo_next : s_lvl[j];
                end
            end
        end
    end

    assign o_pixel = r_pix;

endmodule

[hw/rtl/soft_band_pixel_generator.sv]
// Top level of the soft band pixel generator: beat control and stage wiring.
//
//   Channel  Direction  Handshake                 Beat payload
//   in       sink       i_in_valid / o_in_ready   i_row_index, i_col_index
//   out      source     o_out_valid / i_out_ready o_pixel_value
//   cfg      sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One pixel is accepted per clock unless a stalled output has filled every stage. Three stages
// form the projection and edge distances, three classify the band and build the ramp
// numerator, and eight stages of a restoring divider give one quotient bit each.
// Every stage has its own valid bit and moves when it is empty or its successor moves, so
// a stalled output only stops input once every stage holds a pixel; no beat is lost or
// repeated. Reset (synchronous, active low) empties the pipeline and loads the register
// defaults; there is no clearing pass.
module soft_band_pixel_generator #(
    parameter int COORD_WIDTH = sbpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [COORD_WIDTH-1:0]           i_row_index,
    input  logic [COORD_WIDTH-1:0]           i_col_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sbpg_pkg::LVL_W-1:0]       o_pixel_value
);
    import sbpg_pkg::*;

    localparam int NS = NUM_STAGES;
    localparam int DW = diff_w(COORD_WIDTH);

    t_cfg cfg;

    logic [NS-1:0] stage_en;
    logic [NS-1:0] vld_in;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;

    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic                 cls_ramp;
    logic [LVL_W-1:0]     cls_lvl;
    logic [NUM_W-1:0]     cls_num;

    // A stage takes a new beat when it is empty or its content moves on.
    assign stage_en[NS-1] = !r_vld[NS-1] || i_out_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign stage_en[k] = !r_vld[k] || stage_en[k+1];
    end

    assign vld_in = {r_vld[NS-2:0], i_in_valid};
    assign n_vld  = (vld_in & stage_en) | (r_vld & ~stage_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[NS-1];

    sbpg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbpg_proj #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_proj (
        .i_clk (i_clk),
        .i_en  (stage_en[PROJ_STAGES-1:0]),
        .i_row (i_row_index),
        .i_col (i_col_index),
        .i_cfg (cfg),
        .o_d0  (d0),
        .o_d1  (d1)
    );

    sbpg_cls #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cls (
        .i_clk  (i_clk),
        .i_en   (stage_en[PROJ_STAGES +: CLS_STAGES]),
        .i_d0   (d0),
        .i_d1   (d1),
        .i_cfg  (cfg),
        .o_ramp (cls_ramp),
        .o_lvl  (cls_lvl),
        .o_num  (cls_num)
    );

    sbpg_div u_div (
        .i_clk   (i_clk),
        .i_en    (stage_en[PROJ_STAGES + CLS_STAGES +: DIV_STAGES]),
        .i_ramp  (cls_ramp),
        .i_lvl   (cls_lvl),
        .i_num   (cls_num),
        .i_hw    (cfg.ramp_half_width),
        .o_pixel (o_pixel_value)
    );

`ifndef NO_ASSERTIONS
    // Input is refused only when every stage is occupied.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input refused while the pipeline has a bubble");

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat missing from the first stage");

    // A bubble ahead of a free output stage reaches the output, so no beat is repeated.
    a_bubble_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[NS-2] && (!o_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("output beat repeated or invented");
`endif

endmodule

[bench/soft_band_pixel_generator_test.sv]
// Self-checking testbench for the soft band pixel generator, with random idling on both sides.
`timescale 1ns / 1ps

module soft_band_pixel_generator_test;

    import sbpg_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 500000;
    // The pipeline is 14 stages deep; this pause leaves it empty with some margin.
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic [CW-1:0] row;
        logic [CW-1:0] col;
    } t_pixel_coord;

    typedef struct packed {
        logic [CW-1:0]    row;
        logic [CW-1:0]    col;
        logic [LVL_W-1:0] grey;
    } t_grey_expect;

    // Every input starts at a known value, with reset held.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [CW-1:0]         i_row_index = '0;
    logic [CW-1:0]         i_col_index = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [LVL_W-1:0]      o_pixel_value;

    // Shadow copy of the configuration registers, as the block should hold them.
    logic signed [NRM_W-1:0]  nrm_x       = CFG_RESET.normal_x;
    logic signed [NRM_W-1:0]  nrm_y       = CFG_RESET.normal_y;
    logic signed [EDGE_W-1:0] first_dist  = CFG_RESET.first_edge;
    logic signed [EDGE_W-1:0] second_dist = CFG_RESET.second_edge;
    logic        [HW_W-1:0]   ramp_hw     = CFG_RESET.ramp_half_width;
    logic        [LVL_W-1:0]  grey_low    = CFG_RESET.level_low;
    logic        [LVL_W-1:0]  grey_mid    = CFG_RESET.level_mid;
    logic        [LVL_W-1:0]  grey_high   = CFG_RESET.level_high;

    t_pixel_coord pending_pixels[$];
    t_grey_expect expected_grey[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  hold_cycles    = 0;
    // Set for the closing phases, where both sides run flat out.
    logic steady_flow   = 1'b0;

    soft_band_pixel_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value)
    );

    always #5 i_clk = ~i_clk;

    // Linear blend across one ramp. The caller guarantees -h <= t < h with h > 0, so
    // both weights are non-negative and integer division floors.
    function automatic logic [LVL_W-1:0] blend_levels(logic [LVL_W-1:0] lo,
                                                      logic [LVL_W-1:0] hi,
                                                      longint t, longint h);
        longint num;
        num = longint'(lo) * (h - t) + longint'(hi) * (t + h);
        return LVL_W'(num / (2 * h));
    endfunction

    // Grey value for one pixel under the current shadow configuration. The projection
    // is Q.14 and the edges are Q.4, so the edges are scaled up by 1024 before the
    // comparisons, which run strictly in band order.
    function automatic logic [LVL_W-1:0] predict_grey(logic [CW-1:0] row,
                                                      logic [CW-1:0] col);
        longint proj;
        longint e0;
        longint e1;
        longint h;
        proj = longint'(nrm_x) * longint'(row) + longint'(nrm_y) * longint'(col);
        e0   = longint'(first_dist) * 1024;
        e1   = longint'(second_dist) * 1024;
        h    = longint'(ramp_hw) * 1024;
        if (proj < e0 - h)
            return grey_low;
        else if (proj < e0 + h)
            return blend_levels(grey_low, grey_mid, proj - e0, h);
        else if (proj < e1 - h)
            return grey_mid;
        else if (proj < e1 + h)
            return blend_levels(grey_mid, grey_high, proj - e1, h);
        else
            return grey_high;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // One register write per clock edge; the shadow copy follows at once, which is safe
    // because writes only happen while no pixel is in flight.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_NORMAL_X:        nrm_x       = data[NRM_W-1:0];
            CFG_NORMAL_Y:        nrm_y       = data[NRM_W-1:0];
            CFG_FIRST_EDGE:      first_dist  = data[EDGE_W-1:0];
            CFG_SECOND_EDGE:     second_dist = data[EDGE_W-1:0];
            CFG_RAMP_HALF_WIDTH: ramp_hw     = data[HW_W-1:0];
            CFG_LEVEL_LOW:       grey_low    = data[LVL_W-1:0];
            CFG_LEVEL_MID:       grey_mid    = data[LVL_W-1:0];
            CFG_LEVEL_HIGH:      grey_high   = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int nx, int ny, int fe, int se, int hw,
                              int lo, int mid, int hi);
        write_reg(CFG_NORMAL_X,        CFG_DATA_W'(nx));
        write_reg(CFG_NORMAL_Y,        CFG_DATA_W'(ny));
        write_reg(CFG_FIRST_EDGE,      CFG_DATA_W'(fe));
        write_reg(CFG_SECOND_EDGE,     CFG_DATA_W'(se));
        write_reg(CFG_RAMP_HALF_WIDTH, CFG_DATA_W'(hw));
        write_reg(CFG_LEVEL_LOW,       CFG_DATA_W'(lo));
        write_reg(CFG_LEVEL_MID,       CFG_DATA_W'(mid));
        write_reg(CFG_LEVEL_HIGH,      CFG_DATA_W'(hi));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(int r, int c);
        t_pixel_coord p;
        p.row = CW'(r);
        p.col = CW'(c);
        pending_pixels.push_back(p);
    endtask

    // Wait until every queued pixel has been sent and every result has come back, then
    // give the pipeline a short pause before the configuration is touched. The check is
    // made at the falling edge, where the queues and the valid line agree with each other.
    task automatic drain;
        while (pending_pixels.size() != 0 || i_in_valid || expected_grey.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One random phase: a fresh configuration and a batch of pixels. Most phases place the
    // edges on the projection of pixels inside a window and draw most pixels from that
    // window, so the ramps and bands are all visited; some use fully random registers.
    task automatic random_phase(int n_items);
        int     nx, ny, fe, se, hw, lo, mid, hi;
        int     r0, c0, rad, span, r, c, k;
        longint proj;
        r0 = $urandom_range(0, COORD_MAX);
        c0 = $urandom_range(0, COORD_MAX);
        case ($urandom_range(0, 2))
            0:       rad = 0;
            1:       rad = 256;
            default: rad = 16;
        endcase
        lo  = $urandom_range(0, 255);
        mid = $urandom_range(0, 255);
        hi  = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
            nx = int'($signed(NRM_W'($urandom)));
            ny = int'($signed(NRM_W'($urandom)));
            fe = int'($signed(EDGE_W'($urandom)));
            se = int'($signed(EDGE_W'($urandom)));
            hw = $urandom_range(0, (1 << HW_W) - 1);
        end else begin
            nx   = $urandom_range(0, 32768) - 16384;
            ny   = $urandom_range(0, 32768) - 16384;
            // Rough width in Q.4 of the projection over the window.
            span = (rad == 0) ? 65520 : rad * 32 + 64;
            r    = clamp(r0 + $urandom_range(0, 2 * rad) - rad, 0, COORD_MAX);
            c    = clamp(c0 + $urandom_range(0, 2 * rad) - rad, 0, COORD_MAX);
            proj = (longint'(nx) * r + longint'(ny) * c) >>> EDGE_SHIFT;
            fe   = clamp(int'(proj), -131072, 131071);
            se   = clamp(fe + $urandom_range(0, span) - span / 8, -131072, 131071);
            case ($urandom_range(0, 5))
                0:       hw = 0;
                1:       hw = (1 << HW_W) - 1;
                default: hw = clamp($urandom_range(1, span / 2 + 1), 1, (1 << HW_W) - 1);
            endcase
        end
        set_config(nx, ny, fe, se, hw, lo, mid, hi);
        for (k = 0; k < n_items; k++) begin
            if (rad == 0 || $urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, COORD_MAX);
                c = $urandom_range(0, COORD_MAX);
            end else begin
                r = clamp(r0 + $urandom_range(0, 2 * rad) - rad, 0, COORD_MAX);
                c = clamp(c0 + $urandom_range(0, 2 * rad) - rad, 0, COORD_MAX);
            end
            queue_pixel(r, c);
        end
        drain();
    endtask

    // Input driver. A beat leaves the slot when it is accepted; the slot is then refilled
    // from the pending queue unless an idle burst is running. The expected grey value is
    // computed at acceptance, against the configuration in force at that moment.
    always @(posedge i_clk) begin
        t_grey_expect e;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                e.row  = i_row_index;
                e.col  = i_col_index;
                e.grey = predict_grey(i_row_index, i_col_index);
                expected_grey.push_back(e);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!steady_flow && $urandom_range(0, 15) == 0) begin
                    // This cycle counts as the first of the burst.
                    send_gap = $urandom_range(1, 18) - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_row_index <= pending_pixels[0].row;
                    i_col_index <= pending_pixels[0].col;
                    i_in_valid  <= 1'b1;
                    void'(pending_pixels.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random back-pressure. Each accepted beat is checked against
    // the oldest expectation; a beat with nothing waiting is a failure in itself.
    always @(posedge i_clk) begin
        t_grey_expect e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_grey.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d with no pixel outstanding",
                                              o_pixel_value));
                end else begin
                    e = expected_grey.pop_front();
                    if (o_pixel_value !== e.grey)
                        report_mismatch($sformatf("row %0d col %0d: pixel %0d, wanted %0d",
                                                  e.row, e.col, o_pixel_value, e.grey));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
                hold_cycles = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("soft_band_pixel_generator test failed");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: unit row normal, both edges at zero and hard, so every pixel
        // sits on or beyond both edges. Field extremes on both coordinates.
        queue_pixel(0, 0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD_MAX, 0);
        queue_pixel(0, COORD_MAX);
        drain();

        // Edges at rows 100 and 200 with ramps of 8-pixel half width: walk through each band and each
        // ramp boundary. The second ramp falls, to check interpolation in both senses.
        set_config(16384, 0, 100 * 16, 200 * 16, 8 * 16, 10, 200, 50);
        queue_pixel(91, $urandom_range(0, COORD_MAX));
        queue_pixel(92, $urandom_range(0, COORD_MAX));
        queue_pixel(96, $urandom_range(0, COORD_MAX));
        queue_pixel(100, $urandom_range(0, COORD_MAX));
        queue_pixel(107, $urandom_range(0, COORD_MAX));
        queue_pixel(108, $urandom_range(0, COORD_MAX));
        queue_pixel(192, $urandom_range(0, COORD_MAX));
        queue_pixel(200, $urandom_range(0, COORD_MAX));
        queue_pixel(207, $urandom_range(0, COORD_MAX));
        queue_pixel(208, $urandom_range(0, COORD_MAX));
        drain();

        // Zero half width: hard edges, no ramp at all.
        set_config(16384, 0, 100 * 16, 200 * 16, 0, 0, 128, 255);
        queue_pixel(99, 7);
        queue_pixel(100, 7);
        queue_pixel(199, 7);
        queue_pixel(200, 7);
        drain();

        // Edges out of order: everything past the first ramp must come out at the top level.
        set_config(16384, 0, 200 * 16, 100 * 16, 4 * 16, 30, 90, 240);
        queue_pixel(150, 0);
        queue_pixel(198, 0);
        queue_pixel(300, 0);
        drain();

        // Register extremes: most negative normal code, edges at both ends of their range,
        // widest ramp, and levels at 0 and 255.
        set_config(-32768, -16384, -131072, 131071, (1 << HW_W) - 1, 255, 0, 255);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(0, 0);
        queue_pixel(2048, 100);
        drain();

        // Random phases; the last two run with no idling on either side.
        for (k = 0; k < 13; k++) begin
            if (k == 11)
                steady_flow = 1'b1;
            random_phase(105);
        end

        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_grey.size() == 0)
            $display("soft_band_pixel_generator test passed");
        else
            $display("soft_band_pixel_generator test failed");
        $finish;
    end

endmodule
